@@ hdl/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Types, constants, arithmetic helpers and the control store of the PID
// controller sequencer.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_GAIN_P       = 3'd0;
  localparam logic [2:0] REG_GAIN_I       = 3'd1;
  localparam logic [2:0] REG_GAIN_D       = 3'd2;
  localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd3;
  localparam logic [2:0] REG_INTEG_LIMIT  = 3'd4;
  localparam logic [2:0] REG_DEAD_BAND    = 3'd5;
  localparam logic [2:0] REG_SMOOTHING    = 3'd6;
  localparam logic [2:0] REG_SMOOTHING_ON = 3'd7;

  localparam logic [16:0] Q_ONE  = 17'h10000;  // 1.0 in Q1.16
  localparam logic [31:0] DT_MIN = 32'd16;     // 1 us in Q8.24

  // Quotient of the derivative divide and its bit counter
  localparam int DIV_W = 32;
  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE  = 5'd0;
  localparam step_t ST_DIV   = 5'd10;
  localparam step_t ST_CLAMP = 5'd16;
  localparam step_t ST_EMIT  = 5'd17;
  localparam step_t ST_LAST  = ST_EMIT;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_DBAND,
    OP_EDIFF,
    OP_PTERM,
    OP_RATE,
    OP_TERM,
    OP_ISUM_DABS,
    OP_DINIT,
    OP_DIV,
    OP_DTERM,
    OP_SUM,
    OP_HOLD,
    OP_BLEND,
    OP_CLAMP,
    OP_EMIT
  } uc_op_t;

  typedef enum logic [2:0] {
    MA_GAIN_P,
    MA_GAIN_I,
    MA_RATE,
    MA_GAIN_D,
    MA_WB,
    MA_WA
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_ERR,
    MB_DT,
    MB_EDIFF,
    MB_SUM,
    MB_PREV_DRIVE
  } mul_b_t;

  typedef enum logic [2:0] {
    JC_NEXT,      // advance
    JC_WAIT_IN,   // hold until an input item is taken
    JC_LOOP,      // jump to target until the bit counter is done
    JC_SKIP,      // jump to target when blending is off
    JC_WAIT_OUT,  // hold until the output register is free, then jump
    JC_JUMP       // jump to target
  } uc_jump_t;

  typedef struct packed {
    uc_op_t   op;
    logic     mul_en;
    mul_a_t   ma;
    mul_b_t   mb;
    uc_jump_t jc;
    step_t    target;
  } uc_word_t;

  function automatic uc_word_t uc(input uc_op_t op, input logic mul_en, input mul_a_t ma,
                                  input mul_b_t mb, input uc_jump_t jc, input step_t target);
    uc_word_t w;
    w.op     = op;
    w.mul_en = mul_en;
    w.ma     = ma;
    w.mb     = mb;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step
  function automatic uc_word_t uc_rom(input step_t s);
    uc_word_t w;
    unique case (s)
      5'd0:  w = uc(OP_LOAD,      1'b0, MA_GAIN_P, MB_ERR,        JC_WAIT_IN,  ST_IDLE);
      5'd1:  w = uc(OP_ERR,       1'b0, MA_GAIN_P, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd2:  w = uc(OP_DBAND,     1'b0, MA_GAIN_P, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd3:  w = uc(OP_EDIFF,     1'b1, MA_GAIN_P, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd4:  w = uc(OP_PTERM,     1'b1, MA_GAIN_I, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd5:  w = uc(OP_RATE,      1'b0, MA_GAIN_P, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd6:  w = uc(OP_NONE,      1'b1, MA_RATE,   MB_DT,         JC_NEXT,     ST_IDLE);
      5'd7:  w = uc(OP_TERM,      1'b1, MA_GAIN_D, MB_EDIFF,      JC_NEXT,     ST_IDLE);
      5'd8:  w = uc(OP_ISUM_DABS, 1'b0, MA_GAIN_P, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd9:  w = uc(OP_DINIT,     1'b0, MA_GAIN_P, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd10: w = uc(OP_DIV,       1'b0, MA_GAIN_P, MB_ERR,        JC_LOOP,     ST_DIV);
      5'd11: w = uc(OP_DTERM,     1'b0, MA_GAIN_P, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd12: w = uc(OP_SUM,       1'b0, MA_GAIN_P, MB_ERR,        JC_SKIP,     ST_CLAMP);
      5'd13: w = uc(OP_NONE,      1'b1, MA_WB,     MB_SUM,        JC_NEXT,     ST_IDLE);
      5'd14: w = uc(OP_HOLD,      1'b1, MA_WA,     MB_PREV_DRIVE, JC_NEXT,     ST_IDLE);
      5'd15: w = uc(OP_BLEND,     1'b0, MA_GAIN_P, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd16: w = uc(OP_CLAMP,     1'b0, MA_GAIN_P, MB_ERR,        JC_NEXT,     ST_IDLE);
      5'd17: w = uc(OP_EMIT,      1'b0, MA_GAIN_P, MB_ERR,        JC_WAIT_OUT, ST_IDLE);
      default: w = uc(OP_NONE,    1'b0, MA_GAIN_P, MB_ERR,        JC_JUMP,     ST_IDLE);
    endcase
    return w;
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat66(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Clamp to plus or minus a non-negative limit
  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] x,
                                                   input logic [30:0] lim);
    logic signed [32:0] xl;
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    logic signed [31:0] r;
    xl = 33'(x);
    hi = {2'b00, lim};
    lo = -hi;
    priority if (xl > hi) begin
      r = hi[31:0];
    end else if (xl < lo) begin
      r = lo[31:0];
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

@@ hdl/pid_controller_deadband_filtered.sv @@
// ----------------------------------------------------------------------------
// pid_controller_deadband_filtered
// PID controller with deadband, clamped integral, derivative divide and
// optional low-pass blend of the output, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One input item (measured, target, elapsed) gives one drive item. The result
// is presented after the item is accepted, later with blending on than with
// it off, and may wait in the result register for the sink; the sequencer is
// back at its first step in the same cycle as the result is presented, so a
// new item is taken only once the previous one is through, while the previous
// result may still sit in the output register. The program length is set by
// the 32-step bit-serial divide of the derivative term and by the single
// shared 33x33 multiplier, which the control store uses for one product at a
// time for the P, I, D and blend products. Configuration writes take effect
// at once and belong in idle periods.
module pid_controller_deadband_filtered (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // measured[31:0], target[63:32], elapsed[95:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata    // drive[31:0]
);

  // Configuration
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic [30:0]        output_limit;
  logic [30:0]        integral_limit;
  logic [30:0]        dead_band;
  logic [16:0]        smoothing;
  logic               smoothing_on;

  // Sequencer
  pidc_pkg::step_t    step;
  pidc_pkg::step_t    step_next;
  pidc_pkg::uc_word_t uc;

  // State carried between items
  logic signed [31:0] integral;
  logic signed [31:0] prev_err;
  logic signed [31:0] prev_drive;

  // Datapath
  logic signed [31:0] meas;
  logic signed [31:0] tgt;
  logic [31:0]        dt;
  logic signed [31:0] err;
  logic signed [32:0] ediff;
  logic signed [65:0] prod;
  logic signed [65:0] hold;
  logic signed [31:0] p_term;
  logic signed [31:0] rate;
  logic signed [31:0] term;
  logic signed [31:0] integ_tmp;
  logic [62:0]        dmag;
  logic               dneg;
  logic               dovf;
  logic               dzero;
  logic [31:0]        rem;
  logic [31:0]        lo;
  logic [31:0]        quot;
  logic [pidc_pkg::CNT_W-1:0] cnt;
  logic signed [31:0] d_term;
  logic signed [32:0] psum;
  logic signed [31:0] sum;
  logic [16:0]        wa;
  logic [16:0]        wb;
  logic signed [31:0] res;
  logic [31:0]        out_data;
  logic               out_valid;

  logic               in_acc;
  logic               out_free;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  logic signed [32:0] diff_w;
  logic [31:0]        err_mag;
  logic signed [32:0] isum_w;
  logic [65:0]        prod_abs;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic [32:0]        rem_sub;
  logic               d_big;
  logic signed [31:0] d_w;
  logic signed [33:0] sum_w;
  logic [16:0]        wa_w;
  logic signed [65:0] blend_w;

  assign uc = pidc_pkg::uc_rom(step);

  assign s_axis_tready = !rst && (uc.jc == pidc_pkg::JC_WAIT_IN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Shared multiplier
  always_comb begin
    unique case (uc.ma)
      pidc_pkg::MA_GAIN_P: mul_a = 33'(gain_p);
      pidc_pkg::MA_GAIN_I: mul_a = 33'(gain_i);
      pidc_pkg::MA_RATE:   mul_a = 33'(rate);
      pidc_pkg::MA_GAIN_D: mul_a = 33'(gain_d);
      pidc_pkg::MA_WB:     mul_a = {16'd0, wb};
      pidc_pkg::MA_WA:     mul_a = {16'd0, wa};
      default:             mul_a = '0;
    endcase
    unique case (uc.mb)
      pidc_pkg::MB_ERR:        mul_b = 33'(err);
      pidc_pkg::MB_DT:         mul_b = {1'b0, dt};
      pidc_pkg::MB_EDIFF:      mul_b = ediff;
      pidc_pkg::MB_SUM:        mul_b = 33'(sum);
      pidc_pkg::MB_PREV_DRIVE: mul_b = 33'(prev_drive);
      default:                 mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Step arithmetic
  always_comb begin
    diff_w   = {tgt[31], tgt} - {meas[31], meas};
    err_mag  = err[31] ? (32'd0 - err) : err;
    isum_w   = 33'(integral) + 33'(term);
    prod_abs = prod[65] ? (66'd0 - prod) : prod;
    rem_sh   = {rem, lo[31]};
    rem_ge   = (rem_sh >= {1'b0, dt});
    rem_sub  = rem_sh - {1'b0, dt};
    d_big    = dovf || quot[31];
    if (dzero) begin
      d_w = '0;
    end else if (dneg) begin
      d_w = d_big ? 32'sh80000000 : (32'sd0 - quot);
    end else begin
      d_w = d_big ? 32'sh7fffffff : quot;
    end
    sum_w    = 34'(psum) + 34'(d_term);
    wa_w     = (smoothing > pidc_pkg::Q_ONE) ? pidc_pkg::Q_ONE : smoothing;
    blend_w  = hold + prod;
  end

  // Next step
  always_comb begin
    unique case (uc.jc)
      pidc_pkg::JC_NEXT:     step_next = step + 5'd1;
      pidc_pkg::JC_WAIT_IN:  step_next = in_acc ? step + 5'd1 : step;
      pidc_pkg::JC_LOOP:     step_next = (cnt != pidc_pkg::CNT_LAST) ? uc.target : step + 5'd1;
      pidc_pkg::JC_SKIP:     step_next = smoothing_on ? step + 5'd1 : uc.target;
      pidc_pkg::JC_WAIT_OUT: step_next = out_free ? uc.target : step;
      pidc_pkg::JC_JUMP:     step_next = uc.target;
      default:               step_next = pidc_pkg::ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      output_limit   <= '0;
      integral_limit <= '0;
      dead_band      <= '0;
      smoothing      <= '0;
      smoothing_on   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pidc_pkg::REG_GAIN_P:       gain_p         <= cfg_wdata;
        pidc_pkg::REG_GAIN_I:       gain_i         <= cfg_wdata;
        pidc_pkg::REG_GAIN_D:       gain_d         <= cfg_wdata;
        pidc_pkg::REG_OUTPUT_LIMIT: output_limit   <= cfg_wdata[30:0];
        pidc_pkg::REG_INTEG_LIMIT:  integral_limit <= cfg_wdata[30:0];
        pidc_pkg::REG_DEAD_BAND:    dead_band      <= cfg_wdata[30:0];
        pidc_pkg::REG_SMOOTHING:    smoothing      <= cfg_wdata[16:0];
        pidc_pkg::REG_SMOOTHING_ON: smoothing_on   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= pidc_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      integral   <= '0;
      prev_err   <= '0;
      prev_drive <= '0;
    end else begin
      step <= step_next;
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (uc.op == pidc_pkg::OP_DINIT) begin
        integral <= pidc_pkg::clamp_sym(integ_tmp, integral_limit);
      end
      if (uc.op == pidc_pkg::OP_CLAMP) begin
        prev_err <= err;
      end
      if (uc.op == pidc_pkg::OP_EMIT && out_free) begin
        out_valid  <= 1'b1;
        prev_drive <= res;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (uc.mul_en) begin
      prod <= mul_p;
    end
    if (uc.op == pidc_pkg::OP_EMIT && out_free) begin
      out_data <= res;
    end
    unique case (uc.op)
      pidc_pkg::OP_LOAD: begin
        if (in_acc) begin
          meas <= s_axis_tdata[31:0];
          tgt  <= s_axis_tdata[63:32];
          dt   <= s_axis_tdata[95:64];
        end
      end
      pidc_pkg::OP_ERR: begin
        err <= pidc_pkg::sat66(66'(diff_w));
      end
      pidc_pkg::OP_DBAND: begin
        // zero the error inside the deadband
        if (err_mag < {1'b0, dead_band}) begin
          err <= '0;
        end
      end
      pidc_pkg::OP_EDIFF: begin
        ediff <= 33'(err) - 33'(prev_err);
      end
      pidc_pkg::OP_PTERM: begin
        p_term <= pidc_pkg::sat66(prod >>> 16);
      end
      pidc_pkg::OP_RATE: begin
        rate <= pidc_pkg::sat66(prod >>> 16);
      end
      pidc_pkg::OP_TERM: begin
        term <= pidc_pkg::sat66(prod >>> 24);
      end
      pidc_pkg::OP_ISUM_DABS: begin
        integ_tmp <= pidc_pkg::sat66(66'(isum_w));
        dmag      <= prod_abs[62:0];
        dneg      <= prod[65];
      end
      pidc_pkg::OP_DINIT: begin
        // divide (|prod| << 8) by dt; the top part decides overflow
        dovf  <= (dmag[62:24] >= {7'd0, dt});
        dzero <= (dt <= pidc_pkg::DT_MIN);
        rem   <= dmag[55:24];
        lo    <= {dmag[23:0], 8'd0};
        quot  <= '0;
        cnt   <= '0;
      end
      pidc_pkg::OP_DIV: begin
        rem  <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
        quot <= {quot[30:0], rem_ge};
        lo   <= {lo[30:0], 1'b0};
        cnt  <= cnt + pidc_pkg::CNT_ONE;
      end
      pidc_pkg::OP_DTERM: begin
        d_term <= d_w;
        psum   <= 33'(p_term) + 33'(integral);
      end
      pidc_pkg::OP_SUM: begin
        sum <= pidc_pkg::sat66(66'(sum_w));
        wa  <= wa_w;
        wb  <= pidc_pkg::Q_ONE - wa_w;
      end
      pidc_pkg::OP_HOLD: begin
        hold <= prod;
      end
      pidc_pkg::OP_BLEND: begin
        // weights add up to one, so the floored blend stays in range
        sum <= blend_w[47:16];
      end
      pidc_pkg::OP_CLAMP: begin
        res <= pidc_pkg::clamp_sym(sum, output_limit);
      end
      default: ;
    endcase
  end

  // Assertions
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= pidc_pkg::ST_LAST)
    else $error("step counter outside the control store");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (step == pidc_pkg::ST_IDLE + 5'd1) && !s_axis_tready)
    else $error("accepted item did not start the program");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (uc.op == pidc_pkg::OP_DTERM && !dovf && !dzero) |-> (rem < dt))
    else $error("divide remainder not below divisor");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (uc.op == pidc_pkg::OP_EMIT && out_free) |=>
      m_axis_tvalid && (step == pidc_pkg::ST_IDLE))
    else $error("result not presented after emit step");

endmodule
